### hdl/qst_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qst_pkg: shared definitions for the source tokenizer
// Token kinds, error codes, scan modes and the sizes of the token and
// result-group records that travel between the front and the back.
// ---------------------------------------------------------------------------
package qst_pkg;

  // Default sizes handed to the top level.
  localparam int OFFSET_BITS_DEF = 30;
  localparam int FIFO_DEPTH_DEF  = 4;

  // One input byte causes at most this many tokens.
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;
  localparam int KIND_W      = 3;
  localparam int ERR_W       = 3;
  localparam int LINE_W      = 32;
  localparam int SYM_W       = 8;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_END    = 3'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 3'd1;
  localparam logic [KIND_W-1:0] K_NUMBER = 3'd2;
  localparam logic [KIND_W-1:0] K_STRING = 3'd3;
  localparam logic [KIND_W-1:0] K_SYMBOL = 3'd4;
  localparam logic [KIND_W-1:0] K_ERROR  = 3'd5;

  // Error codes.
  localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] E_UNTERM   = 3'd1;
  localparam logic [ERR_W-1:0] E_ESCAPE   = 3'd2;
  localparam logic [ERR_W-1:0] E_EXPONENT = 3'd3;
  localparam logic [ERR_W-1:0] E_COMMENT  = 3'd4;

  // Scanner modes.
  typedef enum logic [3:0] {
    SM_IDLE    = 4'd0,
    SM_IDENT   = 4'd1,
    SM_INT     = 4'd2,
    SM_FRAC    = 4'd3,
    SM_EXP     = 4'd4,
    SM_EXPSIGN = 4'd5,
    SM_EXPDIG  = 4'd6,
    SM_STRING  = 4'd7,
    SM_DOT     = 4'd8,
    SM_SLASH   = 4'd9,
    SM_LINECOM = 4'd10,
    SM_BLOCK   = 4'd11,
    SM_SINK    = 4'd12
  } scan_mode_t;

  // Width of one token record for a given offset width.
  function automatic int tok_width(input int ow);
    return KIND_W + ERR_W + 2 * ow + LINE_W + SYM_W;
  endfunction

  // Width of the group of tokens caused by one item, with its count.
  function automatic int pkt_width(input int ow);
    return CNT_W + MAX_RESULTS * tok_width(ow);
  endfunction

endpackage
`default_nettype wire

### hdl/qst_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qst_front: byte classifier and scanner state
// Takes at most one byte per accepted item, advances the scanner and builds the
// group of tokens that the byte (and an end marker) completes.
// ---------------------------------------------------------------------------
module qst_front #(
  parameter int OFFSET_BITS = qst_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      accept,
  input  wire logic [7:0]                                char_code,
  input  wire logic                                      has_char,
  input  wire logic                                      end_of_text,
  output logic                                           q_wr_en,
  output logic [qst_pkg::pkt_width(OFFSET_BITS)-1:0]     q_wr_data
);
  import qst_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [ERR_W-1:0]       err;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_W-1:0]      line;
    logic [SYM_W-1:0]       sym;
  } tok_t;

  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    tok_t [MAX_RESULTS-1:0]       slot;
  } pkt_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // Build one token record.
  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                  input logic [ERR_W-1:0] err,
                                  input logic [OFFSET_BITS-1:0] start,
                                  input logic [OFFSET_BITS-1:0] len,
                                  input logic [LINE_W-1:0] line,
                                  input logic [SYM_W-1:0] sym);
    tok_t t;
    t.kind  = kind;
    t.err   = err;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.sym   = sym;
    return t;
  endfunction

  // Append a token to the group, dropping it if the group is full.
  function automatic pkt_t add_tok(input pkt_t p, input tok_t t);
    pkt_t r;
    r = p;
    if (r.cnt != CNT_W'(MAX_RESULTS)) begin
      r.slot[r.cnt] = t;
      r.cnt = r.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  scan_mode_t             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [LINE_W-1:0]      line_r, line_nxt;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt;
  logic [LINE_W-1:0]      bline_r, bline_nxt;
  logic                   star_r, star_nxt;
  pkt_t                   pkt;
  logic                   go_idle;
  logic                   with_end;

  // Character classes of the incoming byte.
  logic is_alpha, is_digit, is_space, is_word;
  assign is_alpha = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5A));
  assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_space = (char_code == 8'h20) ||
                    ((char_code >= 8'h09) && (char_code <= CH_CR));
  assign is_word  = is_alpha || is_digit || (char_code == CH_UNDER);

  // Next scanner state and the token group for this item.
  always_comb begin
    mode_nxt   = mode_r;
    offset_nxt = offset_r;
    line_nxt   = line_r;
    begin_nxt  = begin_r;
    bline_nxt  = bline_r;
    star_nxt   = star_r;
    pkt        = '0;
    go_idle    = 1'b0;
    with_end   = 1'b1;

    if (has_char) begin
      case (mode_r)
        SM_IDENT: begin
          if (!is_word) begin
            pkt = add_tok(pkt, mk_tok(K_IDENT, E_NONE, begin_nxt,
                                      offset_nxt - begin_nxt, bline_nxt, '0));
            go_idle = 1'b1;
          end
        end
        SM_INT, SM_FRAC, SM_EXPDIG: begin
          if (!is_digit) begin
            if ((mode_r == SM_INT) && (char_code == CH_DOT)) begin
              mode_nxt = SM_FRAC;
            end else if ((mode_r != SM_EXPDIG) &&
                         ((char_code == CH_LOW_E) || (char_code == CH_UP_E))) begin
              mode_nxt = SM_EXP;
            end else begin
              pkt = add_tok(pkt, mk_tok(K_NUMBER, E_NONE, begin_nxt,
                                        offset_nxt - begin_nxt, bline_nxt, '0));
              go_idle = 1'b1;
            end
          end
        end
        SM_EXP: begin
          if ((char_code == CH_PLUS) || (char_code == CH_MINUS)) begin
            mode_nxt = SM_EXPSIGN;
          end else if (is_digit) begin
            mode_nxt = SM_EXPDIG;
          end else begin
            pkt = add_tok(pkt, mk_tok(K_ERROR, E_EXPONENT, begin_nxt, '0,
                                      bline_nxt, '0));
            mode_nxt = SM_SINK;
          end
        end
        SM_EXPSIGN: begin
          if (is_digit) begin
            mode_nxt = SM_EXPDIG;
          end else begin
            pkt = add_tok(pkt, mk_tok(K_ERROR, E_EXPONENT, begin_nxt, '0,
                                      bline_nxt, '0));
            mode_nxt = SM_SINK;
          end
        end
        SM_STRING: begin
          if (char_code == CH_QUOTE) begin
            pkt = add_tok(pkt, mk_tok(K_STRING, E_NONE, begin_nxt,
                                      offset_nxt - begin_nxt, bline_nxt, '0));
            mode_nxt = SM_IDLE;
          end else if ((char_code == CH_LF) || (char_code == CH_CR)) begin
            pkt = add_tok(pkt, mk_tok(K_ERROR, E_UNTERM, begin_nxt, '0,
                                      bline_nxt, '0));
            mode_nxt = SM_SINK;
          end else if (char_code == CH_BSLASH) begin
            pkt = add_tok(pkt, mk_tok(K_ERROR, E_ESCAPE, begin_nxt, '0,
                                      bline_nxt, '0));
            mode_nxt = SM_SINK;
          end
        end
        SM_DOT: begin
          if (is_digit) begin
            mode_nxt = SM_FRAC;
          end else begin
            pkt = add_tok(pkt, mk_tok(K_SYMBOL, E_NONE, begin_nxt,
                                      OFFSET_BITS'(1), bline_nxt, CH_DOT));
            go_idle = 1'b1;
          end
        end
        SM_SLASH: begin
          if (char_code == CH_SLASH) begin
            mode_nxt = SM_LINECOM;
          end else if (char_code == CH_STAR) begin
            mode_nxt = SM_BLOCK;
            star_nxt = 1'b0;
          end else begin
            pkt = add_tok(pkt, mk_tok(K_SYMBOL, E_NONE, begin_nxt,
                                      OFFSET_BITS'(1), bline_nxt, CH_SLASH));
            go_idle = 1'b1;
          end
        end
        SM_LINECOM: begin
          if (char_code == CH_LF) begin
            if (line_nxt != LINE_MAX) begin
              line_nxt = line_nxt + LINE_W'(1);
            end
            mode_nxt = SM_IDLE;
          end
        end
        SM_BLOCK: begin
          if (star_r && (char_code == CH_SLASH)) begin
            star_nxt = 1'b0;
            mode_nxt = SM_IDLE;
          end else begin
            if ((char_code == CH_LF) && (line_nxt != LINE_MAX)) begin
              line_nxt = line_nxt + LINE_W'(1);
            end
            star_nxt = (char_code == CH_STAR);
          end
        end
        SM_SINK: begin
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      // The byte starts something new from between tokens.
      if (go_idle) begin
        mode_nxt = SM_IDLE;
        if (is_alpha || (char_code == CH_UNDER)) begin
          mode_nxt  = SM_IDENT;
          begin_nxt = offset_nxt;
          bline_nxt = line_nxt;
        end else if (is_digit) begin
          mode_nxt  = SM_INT;
          begin_nxt = offset_nxt;
          bline_nxt = line_nxt;
        end else if (char_code == CH_DOT) begin
          mode_nxt  = SM_DOT;
          begin_nxt = offset_nxt;
          bline_nxt = line_nxt;
        end else if (char_code == CH_QUOTE) begin
          mode_nxt  = SM_STRING;
          begin_nxt = offset_nxt + OFFSET_BITS'(1);
          bline_nxt = line_nxt;
        end else if (char_code == CH_SLASH) begin
          mode_nxt  = SM_SLASH;
          begin_nxt = offset_nxt;
          bline_nxt = line_nxt;
        end else if (is_space) begin
          if ((char_code == CH_LF) && (line_nxt != LINE_MAX)) begin
            line_nxt = line_nxt + LINE_W'(1);
          end
        end else begin
          pkt = add_tok(pkt, mk_tok(K_SYMBOL, E_NONE, offset_nxt,
                                    OFFSET_BITS'(1), line_nxt, char_code));
        end
      end

      offset_nxt = offset_nxt + OFFSET_BITS'(1);
    end

    // End of text: flush the open token, then the end token unless the text ended in an error.
    if (end_of_text) begin
      case (mode_nxt)
        SM_IDENT: begin
          pkt = add_tok(pkt, mk_tok(K_IDENT, E_NONE, begin_nxt,
                                    offset_nxt - begin_nxt, bline_nxt, '0));
        end
        SM_INT, SM_FRAC, SM_EXPDIG: begin
          pkt = add_tok(pkt, mk_tok(K_NUMBER, E_NONE, begin_nxt,
                                    offset_nxt - begin_nxt, bline_nxt, '0));
        end
        SM_EXP, SM_EXPSIGN: begin
          pkt = add_tok(pkt, mk_tok(K_ERROR, E_EXPONENT, begin_nxt, '0,
                                    bline_nxt, '0));
          with_end = 1'b0;
        end
        SM_STRING: begin
          pkt = add_tok(pkt, mk_tok(K_ERROR, E_UNTERM, begin_nxt, '0,
                                    bline_nxt, '0));
          with_end = 1'b0;
        end
        SM_BLOCK: begin
          pkt = add_tok(pkt, mk_tok(K_ERROR, E_COMMENT, begin_nxt, '0,
                                    bline_nxt, '0));
          with_end = 1'b0;
        end
        SM_DOT: begin
          pkt = add_tok(pkt, mk_tok(K_SYMBOL, E_NONE, begin_nxt,
                                    OFFSET_BITS'(1), bline_nxt, CH_DOT));
        end
        SM_SLASH: begin
          pkt = add_tok(pkt, mk_tok(K_SYMBOL, E_NONE, begin_nxt,
                                    OFFSET_BITS'(1), bline_nxt, CH_SLASH));
        end
        SM_SINK: begin
          with_end = 1'b0;
        end
        default: begin
        end
      endcase
      if (with_end) begin
        pkt = add_tok(pkt, mk_tok(K_END, E_NONE, offset_nxt, '0, line_nxt, '0));
      end
      mode_nxt   = SM_IDLE;
      offset_nxt = '0;
      line_nxt   = LINE_W'(1);
      begin_nxt  = '0;
      bline_nxt  = LINE_W'(1);
      star_nxt   = 1'b0;
    end
  end

  // Queue write: only items that cause tokens leave a group behind.
  always_comb begin
    q_wr_en   = accept && (pkt.cnt != '0);
    q_wr_data = pkt;
  end

  // Scanner registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= SM_IDLE;
      offset_r <= '0;
      line_r   <= LINE_W'(1);
      begin_r  <= '0;
      bline_r  <= LINE_W'(1);
      star_r   <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
      line_r   <= line_nxt;
      begin_r  <= begin_nxt;
      bline_r  <= bline_nxt;
      star_r   <= star_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/qst_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qst_fifo: token group queue
// A short first-in first-out queue that decouples the scanner from the
// token output, so each side can stall on its own.
// ---------------------------------------------------------------------------
module qst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qst_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  import qst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage carries payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### hdl/qst_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qst_back: token output sequencer
// Holds one token group in a register and hands its tokens out one per
// pop, fetching the next group from the queue as the last one leaves.
// ---------------------------------------------------------------------------
module qst_back #(
  parameter int OFFSET_BITS = qst_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [qst_pkg::pkt_width(OFFSET_BITS)-1:0] q_rd_data,
  input  wire logic                                   q_empty,
  output logic                                        q_rd_en,
  input  wire logic                                   pop,
  output logic                                        empty,
  output logic [qst_pkg::KIND_W-1:0]                  token_kind,
  output logic [qst_pkg::ERR_W-1:0]                   error_code,
  output logic [OFFSET_BITS-1:0]                      token_start,
  output logic [OFFSET_BITS-1:0]                      token_length,
  output logic [qst_pkg::LINE_W-1:0]                  line_no,
  output logic [qst_pkg::SYM_W-1:0]                   symbol_char,
  output logic                                        last_of_run
);
  import qst_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [ERR_W-1:0]       err;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_W-1:0]      line;
    logic [SYM_W-1:0]       sym;
  } tok_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    tok_t [MAX_RESULTS-1:0] slot;
  } pkt_t;

  pkt_t             cur_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  tok_t             tok;
  logic             at_last;
  logic             take;

  assign tok     = cur_r.slot[idx_r];
  assign at_last = (idx_r == (cur_r.cnt - CNT_W'(1)));
  assign take    = (!valid_r || (pop && at_last)) && !q_empty;
  assign q_rd_en = take;

  // Advance through the held group or reload from the queue.
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (take) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (valid_r && pop) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= pkt_t'(q_rd_data);
    end
  end

  // Result ports show the token at the current index.
  assign empty        = !valid_r;
  assign token_kind   = tok.kind;
  assign error_code   = tok.err;
  assign token_start  = tok.start;
  assign token_length = tok.len;
  assign line_no      = tok.line;
  assign symbol_char  = tok.sym;
  assign last_of_run  = at_last;

endmodule
`default_nettype wire

### hdl/qasm_source_tokenizer_unit.sv
`default_nettype none
// A token group enters the queue as its byte is accepted, then loads into the output register.
// Throughput: one byte per cycle unless the queue is full; k tokens from one byte need k pops.
// The scanner runs ahead of the output by up to FIFO_DEPTH token groups in the queue.
// Reset: synchronous, active low; scanner returns to offset 0, line 1, queue and output empty.
// ---------------------------------------------------------------------------
// qasm_source_tokenizer_unit: streaming lexer for C-style source text
// A scanner front end turns bytes into token groups, a queue buffers them
// and an output sequencer hands the tokens out one at a time.
// ---------------------------------------------------------------------------
module qasm_source_tokenizer_unit #(
  parameter int OFFSET_BITS = qst_pkg::OFFSET_BITS_DEF,
  parameter int FIFO_DEPTH  = qst_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    in_char_code,
  input  wire logic                          in_has_char,
  input  wire logic                          in_end_of_text,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [qst_pkg::KIND_W-1:0]         out_token_kind,
  output logic [qst_pkg::ERR_W-1:0]          out_error_code,
  output logic [OFFSET_BITS-1:0]             out_token_start,
  output logic [OFFSET_BITS-1:0]             out_token_length,
  output logic [qst_pkg::LINE_W-1:0]         out_line_no,
  output logic [qst_pkg::SYM_W-1:0]          out_symbol_char,
  output logic                               out_last_of_run
);
  import qst_pkg::*;

  localparam int PKT_W = pkt_width(OFFSET_BITS);

  logic             accept;
  logic             q_wr_en;
  logic [PKT_W-1:0] q_wr_data;
  logic             q_rd_en;
  logic [PKT_W-1:0] q_rd_data;
  logic             q_empty;

  // An item enters whenever the queue has room.
  assign accept = push && !full;

  qst_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_char_code),
    .has_char    (in_has_char),
    .end_of_text (in_end_of_text),
    .q_wr_en     (q_wr_en),
    .q_wr_data   (q_wr_data)
  );

  qst_fifo #(
    .WIDTH (PKT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  qst_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_rd_data    (q_rd_data),
    .q_empty      (q_empty),
    .q_rd_en      (q_rd_en),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (out_token_kind),
    .error_code   (out_error_code),
    .token_start  (out_token_start),
    .token_length (out_token_length),
    .line_no      (out_line_no),
    .symbol_char  (out_symbol_char),
    .last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire
